/* sv/isi_pkg.sv */
// Shared constants, codes and types of the interval set insert block.
`timescale 1ns / 1ps
package isi_pkg;

    localparam int NUM_SOURCES_DEF   = 8;
    localparam int MAX_INTERVALS_DEF = 16;

    localparam int ID_W      = 64;
    localparam int SEQ_W     = 63;
    localparam int OUTCOME_W = 3;
    localparam int TOTAL_W   = 5;
    localparam int KIND_W    = 3;

    localparam logic [OUTCOME_W-1:0] OUT_COVERED  = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_EXTENDED = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_MERGED   = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd5;

    // How the first qualifying interval relates to the new number.
    localparam logic [KIND_W-1:0] K_COV  = 3'd0;
    localparam logic [KIND_W-1:0] K_ELO  = 3'd1;
    localparam logic [KIND_W-1:0] K_EHI  = 3'd2;
    localparam logic [KIND_W-1:0] K_EHIM = 3'd3;
    localparam logic [KIND_W-1:0] K_BLW  = 3'd4;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] kind;
    } chain_t;

    typedef struct packed {
        logic we;
        logic load_new;
        logic ins;
        logic mrg;
        logic apnd;
    } cell_ctrl_t;

endpackage

/* sv/isi_channels.sv */
// Request and result channel interfaces of the interval set insert block.
`timescale 1ns / 1ps
interface isi_req_if;
    logic                      valid;
    logic                      ready;
    logic [isi_pkg::ID_W-1:0]  source_id_high;
    logic [isi_pkg::ID_W-1:0]  source_id_low;
    logic [isi_pkg::SEQ_W-1:0] sequence_number;

    modport source (output valid, source_id_high, source_id_low, sequence_number,
                    input ready);
    modport sink (input valid, source_id_high, source_id_low, sequence_number,
                  output ready);
endinterface

interface isi_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [isi_pkg::OUTCOME_W-1:0] outcome;
    logic [isi_pkg::TOTAL_W-1:0]   interval_total;

    modport source (output valid, outcome, interval_total, input ready);
    modport sink (input valid, outcome, interval_total, output ready);
endinterface

/* sv/isi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module isi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/isi_cell.sv */
// One interval slot of the chain: holds entry IDX of every source's list.
`timescale 1ns / 1ps
module isi_cell #(
    parameter int NUM_SOURCES = isi_pkg::NUM_SOURCES_DEF,
    parameter int CNT_W       = 5,
    parameter int IDX         = 0,
    parameter int SRC_W       = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SRC_W-1:0]          addr,
    input  isi_pkg::cell_ctrl_t       ctrl,
    input  logic [isi_pkg::SEQ_W-1:0] seq,
    input  logic [CNT_W-1:0]          cnt,
    input  isi_pkg::chain_t           chain_in,
    output isi_pkg::chain_t           chain_out,
    input  logic [isi_pkg::SEQ_W-1:0] left_start,
    input  logic [isi_pkg::SEQ_W-1:0] left_end,
    input  logic [isi_pkg::SEQ_W-1:0] right_start,
    input  logic [isi_pkg::SEQ_W-1:0] right_end,
    input  logic                      right_touch,
    output logic [isi_pkg::SEQ_W-1:0] start_q,
    output logic [isi_pkg::SEQ_W-1:0] end_q,
    output logic                      touch
);

    localparam int SW = isi_pkg::SEQ_W;

    logic [2*SW-1:0]         rdata;
    logic [2*SW-1:0]         wdata;
    logic [SW-1:0]           st;
    logic [SW-1:0]           en;
    logic [SW-1:0]           new_start;
    logic [SW-1:0]           new_end;
    logic [SW:0]             n_x;
    logic [SW:0]             st_x;
    logic [SW:0]             en_x;
    logic                    live;
    logic                    cov;
    logic                    elo;
    logic                    ehi;
    logic                    blw;
    logic                    qual;
    logic                    first;
    logic                    at_cnt;
    logic [isi_pkg::KIND_W-1:0] kind;
    isi_pkg::chain_t         chain_reg;
    isi_pkg::chain_t         chain_next;

    isi_ram #(
        .WIDTH (2 * SW),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    assign st   = rdata[2*SW-1:SW];
    assign en   = rdata[SW-1:0];
    assign n_x  = {1'b0, seq};
    assign st_x = {1'b0, st};
    assign en_x = {1'b0, en};

    assign live   = CNT_W'(IDX) < cnt;
    assign at_cnt = CNT_W'(IDX) == cnt;
    assign cov    = (seq >= st) && (seq <= en);
    assign elo    = (n_x + 1'b1) == st_x;
    assign ehi    = n_x == (en_x + 1'b1);
    assign blw    = seq < st;
    assign qual   = live && (cov || ehi || blw);
    assign first  = qual && !chain_in.found;
    assign touch  = live && elo;

    always_comb
    begin
        if (cov)
        begin
            kind = isi_pkg::K_COV;
        end
        else if (elo)
        begin
            kind = isi_pkg::K_ELO;
        end
        else if (ehi)
        begin
            kind = right_touch ? isi_pkg::K_EHIM : isi_pkg::K_EHI;
        end
        else
        begin
            kind = isi_pkg::K_BLW;
        end
    end

    // The first hit travels down the chain one cell per cycle.
    always_comb
    begin
        if (chain_in.found)
        begin
            chain_next = chain_in;
        end
        else
        begin
            chain_next.found = qual;
            chain_next.kind  = kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

    // Cells past the hit shift right on insert and left on merge.
    always_comb
    begin
        new_start = st;
        new_end   = en;
        if (ctrl.load_new)
        begin
            new_start = seq;
            new_end   = seq;
        end
        else if (first)
        begin
            case (kind)
                isi_pkg::K_ELO:
                begin
                    new_start = seq;
                end
                isi_pkg::K_EHI:
                begin
                    new_end = seq;
                end
                isi_pkg::K_EHIM:
                begin
                    new_end = right_end;
                end
                isi_pkg::K_BLW:
                begin
                    if (ctrl.ins)
                    begin
                        new_start = seq;
                        new_end   = seq;
                    end
                end
                default:
                begin
                    new_start = st;
                    new_end   = en;
                end
            endcase
        end
        else if (chain_in.found)
        begin
            if (ctrl.ins)
            begin
                new_start = left_start;
                new_end   = left_end;
            end
            else if (ctrl.mrg)
            begin
                new_start = right_start;
                new_end   = right_end;
            end
        end
        else if (ctrl.apnd && at_cnt)
        begin
            new_start = seq;
            new_end   = seq;
        end
    end

    assign wdata   = {new_start, new_end};
    assign start_q = st;
    assign end_q   = en;

endmodule

/* sv/interval_set_insert.sv */
// Top level of the interval set insert block: source lookup, sequencing, cell chain.
`timescale 1ns / 1ps
// Adds sequence numbers to per-source sorted sets of disjoint closed intervals.
// Channel req carries a request (128-bit source identifier, sequence number);
// channel rsp returns one result per request: outcome code and the number of
// intervals now held by that source. Both are valid/ready channels.
// One request is worked on at a time. The source table is scanned one entry
// per cycle through its RAM, the list is read in S_LOAD, the first qualifying
// interval is found as a flag wave that moves one cell per cycle down the
// chain of MAX_INTERVALS cells in S_SETTLE, then all cells write their new
// entry together in S_UPDATE. The result then passes S_DONE into the output
// register, and req is ready again in the same cycle that it turns valid. A
// new source goes through S_NEW instead of the list states, and a dropped one
// goes from the scan straight to S_DONE.
// The result sits in an output register, so req takes the next request while
// a result still waits; a stalled rsp holds the block before the next result.
// Reset clears the source valid bits, so all sources are unknown; the interval
// RAMs need no clearing since only entries below a written count are used.
module interval_set_insert #(
    parameter int NUM_SOURCES   = isi_pkg::NUM_SOURCES_DEF,
    parameter int MAX_INTERVALS = isi_pkg::MAX_INTERVALS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    isi_req_if.sink   req,
    isi_rsp_if.source rsp
);

    localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int ISS_W = $clog2(NUM_SOURCES + 1);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int SET_W = $clog2(MAX_INTERVALS);
    localparam int SW    = isi_pkg::SEQ_W;
    localparam int IW    = isi_pkg::ID_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_SETTLE = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_NEW    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [IW-1:0]                  hi_reg;
    logic [IW-1:0]                  lo_reg;
    logic [SW-1:0]                  seq_reg;
    logic [ISS_W-1:0]               issue_reg;
    logic                           cmp_vld_reg;
    logic [SRC_W-1:0]               cmp_idx_reg;
    logic                           hit_reg;
    logic                           free_found_reg;
    logic [SRC_W-1:0]               free_reg;
    logic [SRC_W-1:0]               src_reg;
    logic [NUM_SOURCES-1:0]         src_valid_reg;
    logic [SET_W-1:0]               settle_reg;
    logic [isi_pkg::OUTCOME_W-1:0]  res_outcome_reg;
    logic [isi_pkg::TOTAL_W-1:0]    res_total_reg;
    logic                           out_valid_reg;
    logic [isi_pkg::OUTCOME_W-1:0]  outcome_reg;
    logic [isi_pkg::TOTAL_W-1:0]    total_reg;

    logic [2*IW-1:0]                id_rdata;
    logic [CNT_W-1:0]               cnt;
    logic [CNT_W-1:0]               cnt_next;
    logic [CNT_W-1:0]               cnt_wdata;
    logic                           scan_done;
    logic                           req_fire;
    logic                           ins;
    logic                           mrg;
    isi_pkg::chain_t                fin;
    isi_pkg::cell_ctrl_t            ctrl;
    logic [isi_pkg::OUTCOME_W-1:0]  upd_outcome;

    logic [SW-1:0]                  start_w [MAX_INTERVALS];
    logic [SW-1:0]                  end_w   [MAX_INTERVALS];
    logic                           touch_w [MAX_INTERVALS];
    isi_pkg::chain_t                chain_w [MAX_INTERVALS];

    assign req.ready = state_reg == S_IDLE;
    assign req_fire  = req.valid && req.ready;
    assign scan_done = (issue_reg == ISS_W'(NUM_SOURCES)) && !cmp_vld_reg;

    isi_ram #(
        .WIDTH (2 * IW),
        .DEPTH (NUM_SOURCES)
    ) u_id_ram (
        .clk   (clk),
        .we    (state_reg == S_NEW),
        .waddr (src_reg),
        .wdata ({hi_reg, lo_reg}),
        .raddr (issue_reg[SRC_W-1:0]),
        .rdata (id_rdata)
    );

    isi_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_SOURCES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    ((state_reg == S_NEW) || (state_reg == S_UPDATE)),
        .waddr (src_reg),
        .wdata (cnt_wdata),
        .raddr (src_reg),
        .rdata (cnt)
    );

    assign fin = chain_w[MAX_INTERVALS-1];
    assign ins = (!fin.found || (fin.kind == isi_pkg::K_BLW)) &&
                 (cnt < CNT_W'(MAX_INTERVALS));
    assign mrg = fin.found && (fin.kind == isi_pkg::K_EHIM);

    always_comb
    begin
        ctrl.we       = (state_reg == S_NEW) || (state_reg == S_UPDATE);
        ctrl.load_new = state_reg == S_NEW;
        ctrl.ins      = ins;
        ctrl.mrg      = mrg;
        ctrl.apnd     = ins && !fin.found;
    end

    always_comb
    begin
        if (mrg)
        begin
            cnt_next = cnt - 1'b1;
        end
        else if (ins)
        begin
            cnt_next = cnt + 1'b1;
        end
        else
        begin
            cnt_next = cnt;
        end
    end

    assign cnt_wdata = (state_reg == S_NEW) ? CNT_W'(1) : cnt_next;

    always_comb
    begin
        if (!fin.found)
        begin
            upd_outcome = ins ? isi_pkg::OUT_INSERTED : isi_pkg::OUT_FULL;
        end
        else
        begin
            case (fin.kind)
                isi_pkg::K_COV:  upd_outcome = isi_pkg::OUT_COVERED;
                isi_pkg::K_ELO:  upd_outcome = isi_pkg::OUT_EXTENDED;
                isi_pkg::K_EHI:  upd_outcome = isi_pkg::OUT_EXTENDED;
                isi_pkg::K_EHIM: upd_outcome = isi_pkg::OUT_MERGED;
                default:         upd_outcome = ins ? isi_pkg::OUT_INSERTED
                                                   : isi_pkg::OUT_FULL;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_INTERVALS; k++)
        begin : g_cell
            logic [SW-1:0]   l_start;
            logic [SW-1:0]   l_end;
            logic [SW-1:0]   r_start;
            logic [SW-1:0]   r_end;
            logic            r_touch;
            isi_pkg::chain_t c_in;

            if (k == 0)
            begin : g_first
                assign l_start = '0;
                assign l_end   = '0;
                assign c_in    = '0;
            end
            else
            begin : g_mid
                assign l_start = start_w[k-1];
                assign l_end   = end_w[k-1];
                assign c_in    = chain_w[k-1];
            end

            if (k == MAX_INTERVALS - 1)
            begin : g_last
                assign r_start = '0;
                assign r_end   = '0;
                assign r_touch = 1'b0;
            end
            else
            begin : g_right
                assign r_start = start_w[k+1];
                assign r_end   = end_w[k+1];
                assign r_touch = touch_w[k+1];
            end

            isi_cell #(
                .NUM_SOURCES (NUM_SOURCES),
                .CNT_W       (CNT_W),
                .IDX         (k),
                .SRC_W       (SRC_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .addr        (src_reg),
                .ctrl        (ctrl),
                .seq         (seq_reg),
                .cnt         (cnt),
                .chain_in    (c_in),
                .chain_out   (chain_w[k]),
                .left_start  (l_start),
                .left_end    (l_end),
                .right_start (r_start),
                .right_end   (r_end),
                .right_touch (r_touch),
                .start_q     (start_w[k]),
                .end_q       (end_w[k]),
                .touch       (touch_w[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (hit_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (free_found_reg)
                    begin
                        state_next = S_NEW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                if (settle_reg == SET_W'(MAX_INTERVALS - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_DONE;
            end
            S_NEW:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            src_valid_reg  <= '0;
            settle_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (req_fire)
            begin
                issue_reg      <= '0;
                cmp_vld_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                if (issue_reg != ISS_W'(NUM_SOURCES))
                begin
                    issue_reg   <= issue_reg + 1'b1;
                    cmp_vld_reg <= 1'b1;
                end
                else
                begin
                    cmp_vld_reg <= 1'b0;
                end
                if (cmp_vld_reg)
                begin
                    if (src_valid_reg[cmp_idx_reg])
                    begin
                        if (!hit_reg && (id_rdata == {hi_reg, lo_reg}))
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == S_NEW)
            begin
                src_valid_reg[src_reg] <= 1'b1;
            end

            if (state_reg == S_SETTLE)
            begin
                settle_reg <= settle_reg + 1'b1;
            end
            else
            begin
                settle_reg <= '0;
            end

            if ((state_reg == S_DONE) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            hi_reg  <= req.source_id_high;
            lo_reg  <= req.source_id_low;
            seq_reg <= req.sequence_number;
        end

        if (state_reg == S_SCAN)
        begin
            cmp_idx_reg <= issue_reg[SRC_W-1:0];
            if (cmp_vld_reg)
            begin
                if (src_valid_reg[cmp_idx_reg])
                begin
                    if (!hit_reg && (id_rdata == {hi_reg, lo_reg}))
                    begin
                        src_reg <= cmp_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_reg <= cmp_idx_reg;
                end
            end
            if (scan_done && !hit_reg)
            begin
                src_reg         <= free_reg;
                res_outcome_reg <= isi_pkg::OUT_FULL;
                res_total_reg   <= '0;
            end
        end

        if (state_reg == S_NEW)
        begin
            res_outcome_reg <= isi_pkg::OUT_NEW;
            res_total_reg   <= isi_pkg::TOTAL_W'(1);
        end

        if (state_reg == S_UPDATE)
        begin
            res_outcome_reg <= upd_outcome;
            res_total_reg   <= isi_pkg::TOTAL_W'(cnt_next);
        end

        if ((state_reg == S_DONE) && (!out_valid_reg || rsp.ready))
        begin
            outcome_reg <= res_outcome_reg;
            total_reg   <= res_total_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.outcome        = outcome_reg;
    assign rsp.interval_total = total_reg;

    // A list never holds more intervals than the chain has cells.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (cnt <= CNT_W'(MAX_INTERVALS)))
        else $error("interval count above capacity");

    // A merge needs two intervals to join.
    a_merge_two: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPDATE) && mrg) |-> (cnt >= CNT_W'(2)))
        else $error("merge with fewer than two intervals");

    // A new source only ever takes a free slot.
    a_new_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEW) |-> !src_valid_reg[src_reg])
        else $error("new source placed on a used slot");

    // An accepted request starts the table scan.
    a_req_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> ((state_reg == S_SCAN) && (issue_reg == '0)))
        else $error("request did not start a scan");

    // The interval list is only touched for a known source.
    a_update_known: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (hit_reg && src_valid_reg[src_reg]))
        else $error("list update for an unknown source");

endmodule
